[src/tcsc_pkg.sv]
// ---------------------------------------------------------------------------
// tcsc_pkg: shared types and constants
// Word layouts for the trigger cell sum unit, plus the limits used by the
// accumulator and the float coder.
// ---------------------------------------------------------------------------
package tcsc_pkg;

   localparam int unsigned ChannelsPerCell = 4;

   localparam int unsigned AdcWidth     = 10;
   localparam int unsigned TotWidth     = 12;
   localparam int unsigned SumWidth     = 19;
   localparam int unsigned CodeWidth    = 7;
   localparam int unsigned DecodedWidth = 21;
   localparam int unsigned CountWidth   = 3;
   localparam int unsigned VWidth       = 18;

   localparam logic [SumWidth-1:0]   SumMax  = 19'h7FFFF;
   localparam logic [VWidth-1:0]     CodeMax = 18'h3FFFF;
   localparam logic [CountWidth-1:0] TotCap  =
      CountWidth'((ChannelsPerCell < 7) ? ChannelsPerCell : 7);
   localparam logic [TotWidth-1:0]   TotSatLevel = 12'd512;
   localparam logic [4:0]            TotScale    = 5'd25;

   // tot_flag codes
   localparam logic [1:0] TOT_FLAG_ADC   = 2'd0;
   localparam logic [1:0] TOT_FLAG_VALID = 2'd3;

   typedef struct packed {
      logic [AdcWidth-1:0] adc_value;
      logic [TotWidth-1:0] tot_value;
      logic [1:0]          tot_flag;
      logic                last_channel;
   } req_type;

   typedef struct packed {
      logic [SumWidth-1:0]     linear_sum;
      logic [CodeWidth-1:0]    compressed_sum;
      logic [DecodedWidth-1:0] decompressed_sum;
      logic                    sum_valid;
      logic [CountWidth-1:0]   tot_channel_count;
      logic                    tot_saturated;
   } rsp_type;

   // finished cell, handed from the accumulator to the coder stage
   typedef struct packed {
      logic [SumWidth-1:0]   sum;
      logic                  incomplete;
      logic [CountWidth-1:0] count;
      logic                  saturated;
      logic                  low_density;
   } cell_type;

endpackage

[src/tcsc_codec.sv]
// ---------------------------------------------------------------------------
// tcsc_codec: 4e3m float coder and decoder
// Shifts and clamps the linear sum, finds the leading one to form the
// exponent/mantissa code, and rebuilds the value with its midpoint bit.
// ---------------------------------------------------------------------------
module tcsc_codec (
   input  logic [tcsc_pkg::SumWidth-1:0]     sum,
   input  logic                              low_density,
   output logic [tcsc_pkg::CodeWidth-1:0]    code,
   output logic [tcsc_pkg::DecodedWidth-1:0] decoded
);

   always_comb begin
      logic [tcsc_pkg::VWidth-1:0]   v;
      logic [tcsc_pkg::VWidth-1:0]   shifted;
      logic [4:0]                    p;
      logic [3:0]                    ex;
      logic [2:0]                    mant;
      logic [4:0]                    q;
      logic [tcsc_pkg::DecodedWidth-1:0] val;

      v = low_density ? tcsc_pkg::VWidth'(sum >> 1) : tcsc_pkg::VWidth'(sum >> 3);
      if (v > tcsc_pkg::CodeMax) begin
         v = tcsc_pkg::CodeMax;
      end

      // leading-one position
      p = 5'd0;
      for (int i = 0; i < int'(tcsc_pkg::VWidth); i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end

      shifted = v;
      if (v <= tcsc_pkg::VWidth'(7)) begin
         ex   = 4'd0;
         mant = v[2:0];
      end else begin
         shifted = v >> (p - 5'd3);
         ex      = 4'(p - 5'd2);
         mant    = shifted[2:0];
      end
      code = {ex, mant};

      // rebuild; no midpoint bit for exponent 1
      q = 5'(ex) + 5'd2;
      if (ex == 4'd0) begin
         val = tcsc_pkg::DecodedWidth'(mant);
      end else begin
         val = (tcsc_pkg::DecodedWidth'(1) << q)
             | (tcsc_pkg::DecodedWidth'(mant) << (q - 5'd3));
         if (ex >= 4'd2) begin
            val = val | (tcsc_pkg::DecodedWidth'(1) << (q - 5'd4));
         end
      end
      decoded = low_density ? (val << 1) : (val << 3);
   end

endmodule

[src/trigger_cell_sum_compress_unit.sv]
// ---------------------------------------------------------------------------
// trigger_cell_sum_compress_unit: trigger cell energy sum and float coder
// Accumulates channel samples of one trigger cell and, on the last channel,
// emits the linear sum, its 4e3m code, the decoded value and status flags.
// ---------------------------------------------------------------------------
//
//   port group | dir | word        | notes
//   -----------+-----+-------------+-----------------------------------------
//   req_       | in  | req_type    | one channel sample per word
//   rsp_       | out | rsp_type    | one word per trigger cell (last channel)
//   csr_       | in  | 1-bit data  | low_density_mode, always ready
//
// A sample word can be taken every cycle while req_ready is high. The result
// word is offered once the last channel has passed the input register: the
// accumulator loads the cell register, then the coder the output register.
// Reset clears all valid bits and the running state; low_density_mode
// resets to 1. A stalled rsp_ready backs up one stage at a time, so
// req_ready drops only once all three stages hold words.
module trigger_cell_sum_compress_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tcsc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tcsc_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data
);

   logic                  ldm_ff;
   logic                  in_vld_ff;
   tcsc_pkg::req_type     in_ff;
   logic [tcsc_pkg::SumWidth-1:0]   sum_ff,   sum_in;
   logic [tcsc_pkg::CountWidth-1:0] count_ff, count_in;
   logic                  incomplete_ff, incomplete_in;
   logic                  saturated_ff,  saturated_in;
   logic                  cell_vld_ff;
   tcsc_pkg::cell_type    cell_ff, cell_in;
   logic                  rsp_vld_ff;
   tcsc_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  in_go, cell_go, cell_free;
   logic [tcsc_pkg::CodeWidth-1:0]    code;
   logic [tcsc_pkg::DecodedWidth-1:0] decoded;

   assign csr_ready = 1'b1;
   assign cell_go   = cell_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign cell_free = !cell_vld_ff || cell_go;
   assign in_go     = in_vld_ff && (!in_ff.last_channel || cell_free);
   assign req_ready = !in_vld_ff || in_go;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // accumulate one sample onto the running state
   always_comb begin
      logic [tcsc_pkg::SumWidth:0] total;
      logic [16:0]                 add;

      incomplete_in = incomplete_ff;
      saturated_in  = saturated_ff;
      count_in      = count_ff;
      if (in_ff.tot_flag == tcsc_pkg::TOT_FLAG_VALID) begin
         add = 17'(in_ff.tot_value) * 17'(tcsc_pkg::TotScale);
         if (count_ff < tcsc_pkg::TotCap) begin
            count_in = count_ff + 3'd1;
         end
         if (in_ff.tot_value >= tcsc_pkg::TotSatLevel) begin
            saturated_in = 1'b1;
         end
      end else begin
         add = 17'(in_ff.adc_value);
         if (in_ff.tot_flag != tcsc_pkg::TOT_FLAG_ADC) begin
            incomplete_in = 1'b1;
         end
      end
      total = 20'(sum_ff) + 20'(add);
      sum_in = total[tcsc_pkg::SumWidth] ? tcsc_pkg::SumMax
                                         : total[tcsc_pkg::SumWidth-1:0];

      cell_in.sum         = sum_in;
      cell_in.incomplete  = incomplete_in;
      cell_in.count       = count_in;
      cell_in.saturated   = saturated_in;
      cell_in.low_density = ldm_ff;
   end

   tcsc_codec u_codec (
      .sum         (cell_ff.sum),
      .low_density (cell_ff.low_density),
      .code        (code),
      .decoded     (decoded)
   );

   always_comb begin
      rsp_in.linear_sum        = cell_ff.sum;
      rsp_in.compressed_sum    = code;
      rsp_in.decompressed_sum  = decoded;
      rsp_in.sum_valid         = !cell_ff.incomplete;
      rsp_in.tot_channel_count = cell_ff.count;
      rsp_in.tot_saturated     = cell_ff.saturated;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ldm_ff        <= 1'b1;
         in_vld_ff     <= 1'b0;
         cell_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         sum_ff        <= '0;
         count_ff      <= '0;
         incomplete_ff <= 1'b0;
         saturated_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            ldm_ff <= csr_data;
         end

         if (req_ready) begin
            in_vld_ff <= req_valid;
         end

         if (in_go) begin
            if (in_ff.last_channel) begin
               // cell done: state starts over
               sum_ff        <= '0;
               count_ff      <= '0;
               incomplete_ff <= 1'b0;
               saturated_ff  <= 1'b0;
            end else begin
               sum_ff        <= sum_in;
               count_ff      <= count_in;
               incomplete_ff <= incomplete_in;
               saturated_ff  <= saturated_in;
            end
         end

         if (cell_free) begin
            cell_vld_ff <= in_go && in_ff.last_channel;
         end

         if (cell_go) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
      if (cell_free && in_go && in_ff.last_channel) begin
         cell_ff <= cell_in;
      end
      if (cell_go) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
